// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the pump controller rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expression holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("%m: invariant violated");

// antecedent at one edge implies consequent at the next edge
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`else

`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: rtl/core/ipc_pkg.sv
// ----------------------------------------------------------------------------
// ipc_pkg
// types and constants shared by the irrigation pump controller
// ----------------------------------------------------------------------------
`default_nettype none

package ipc_pkg;

   // default width of the manual watering timer
   localparam int TIMER_BITS_DEFAULT = 16;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_LOW_THRESHOLD   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HIGH_THRESHOLD  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MANUAL_DURATION = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_READ_INTERVAL   = 2'd3;

   // register reset values
   localparam logic [9:0]  LOW_THRESHOLD_RESET   = 10'd300;
   localparam logic [9:0]  HIGH_THRESHOLD_RESET  = 10'd600;
   localparam logic [15:0] MANUAL_DURATION_RESET = 16'd10;
   localparam logic [15:0] READ_INTERVAL_RESET   = 16'd1;

   // indicator codes
   localparam logic [1:0] IND_NORMAL   = 2'd0;
   localparam logic [1:0] IND_WATERING = 2'd1;
   localparam logic [1:0] IND_ALERT    = 2'd2;
   localparam logic [1:0] IND_UNUSED   = 2'd3;

   // one tick item
   typedef struct packed {
      logic       toggle_press;
      logic       water_press;
      logic [9:0] moisture_sample;
   } req_item_type;

   // one result item
   typedef struct packed {
      logic        pump_on;
      logic [1:0]  led_code;
      logic        auto_flag;
      logic [15:0] manual_left;
   } rsp_item_type;

endpackage

`default_nettype wire

// File: rtl/core/ipc_stream_if.sv
// ----------------------------------------------------------------------------
// ipc_stream_if
// valid/ready channel carrying one item of a given type
// ----------------------------------------------------------------------------
`default_nettype none

interface ipc_stream_if
   import ipc_pkg::*;
#(
   parameter type item_type = req_item_type
);

   logic     valid;
   logic     ready;
   item_type item;

   modport source (output valid, output item, input ready);
   modport sink   (input valid, input item, output ready);

endinterface

`default_nettype wire

// File: rtl/core/irrigation_pump_controller.sv
// ----------------------------------------------------------------------------
// irrigation_pump_controller
// on/off hysteresis pump controller with a manual watering timer
// ----------------------------------------------------------------------------
// usage
//   req_chan carries one tick item per second: toggle press, water press and
//   a moisture sample in tenths of a percent. rsp_chan returns exactly one
//   item per tick: pump drive, indicator code, mode and manual ticks left.
//   csr_* writes the four thresholds/timing registers; write only while idle.
// datapath and throughput
//   a tick is captured in an input register; its result is computed from it
//   and loaded into the output register, which drives rsp valid and item.
//   one item per cycle is sustained while rsp ready stays high: the tick
//   update is a few compares and counter steps between the two registers.
// reset
//   synchronous, active high: auto mode, pump off, indicator normal, timer
//   and sample phase cleared (first tick latches a sample), registers at
//   their defaults, both pipeline stages empty.
// stalls
//   when rsp ready is low the output register holds its item; the input
//   register still takes one more tick, then req ready drops until the
//   output moves on.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module irrigation_pump_controller
   import ipc_pkg::*;
#(
   parameter int TIMER_BITS = TIMER_BITS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   ipc_stream_if.sink                  req_chan,
   ipc_stream_if.source                rsp_chan,
   input  wire logic                   csr_write,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   // common width for timer saturation compares
   localparam int WIDE_BITS = (TIMER_BITS > 16) ? TIMER_BITS : 16;

   // configuration registers
   logic [9:0]  low_threshold_ff;
   logic [9:0]  high_threshold_ff;
   logic [15:0] manual_duration_ff;
   logic [15:0] read_interval_ff;

   // pipeline registers
   logic         in_valid_ff;
   req_item_type in_item_ff;
   logic         out_valid_ff;
   rsp_item_type out_item_ff;

   // controller state
   logic                  auto_mode_ff,   auto_mode_in;
   logic                  pump_ff,        pump_in;
   logic [1:0]            indicator_ff,   indicator_in;
   logic [TIMER_BITS-1:0] timer_ff,       timer_in;
   logic [15:0]           phase_ff,       phase_in;
   logic [9:0]            moisture_ff,    moisture_in;

   logic                 advance;
   logic                 req_take;
   logic [WIDE_BITS-1:0] duration_wide;
   logic [WIDE_BITS-1:0] timer_max_wide;
   logic [WIDE_BITS-1:0] reload_wide;
   logic [WIDE_BITS-1:0] timer_wide;
   logic [15:0]          phase_inc;
   logic [15:0]          manual_left;

   // handshake: output register empties or is taken, so the input can move
   assign advance        = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.item  = out_item_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         low_threshold_ff   <= LOW_THRESHOLD_RESET;
         high_threshold_ff  <= HIGH_THRESHOLD_RESET;
         manual_duration_ff <= MANUAL_DURATION_RESET;
         read_interval_ff   <= READ_INTERVAL_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_LOW_THRESHOLD:   low_threshold_ff   <= csr_data[9:0];
            CSR_HIGH_THRESHOLD:  high_threshold_ff  <= csr_data[9:0];
            CSR_MANUAL_DURATION: manual_duration_ff <= csr_data;
            CSR_READ_INTERVAL:   read_interval_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // timer reload saturates at the timer range
   assign duration_wide  = WIDE_BITS'(manual_duration_ff);
   assign timer_max_wide = WIDE_BITS'({TIMER_BITS{1'b1}});
   assign reload_wide    = (duration_wide > timer_max_wide) ? timer_max_wide : duration_wide;

   // one tick of the controller
   always_comb begin
      auto_mode_in = auto_mode_ff;
      pump_in      = pump_ff;
      indicator_in = indicator_ff;
      timer_in     = timer_ff;
      moisture_in  = moisture_ff;

      if (timer_ff != '0) begin
         timer_in = timer_ff - TIMER_BITS'(1);
      end

      // mode toggle, entering manual stops the pump
      if (in_item_ff.toggle_press) begin
         auto_mode_in = !auto_mode_ff;
         if (auto_mode_ff && pump_ff) begin
            pump_in      = 1'b0;
            indicator_in = IND_NORMAL;
         end
      end

      // manual press reloads the timer and starts the pump
      if (!auto_mode_in && in_item_ff.water_press) begin
         timer_in = TIMER_BITS'(reload_wide);
         if (!pump_in) begin
            pump_in      = 1'b1;
            indicator_in = IND_WATERING;
         end
      end

      // sample latch and idle indicator
      if (phase_ff == '0) begin
         moisture_in = in_item_ff.moisture_sample;
         if (!pump_in) begin
            indicator_in = (auto_mode_in && (moisture_in < low_threshold_ff)) ?
                           IND_ALERT : IND_NORMAL;
         end
      end

      // hysteresis rule or manual timeout
      if (auto_mode_in) begin
         if ((moisture_in < low_threshold_ff) && !pump_in) begin
            pump_in      = 1'b1;
            indicator_in = IND_WATERING;
         end
         if (pump_in && (moisture_in > high_threshold_ff)) begin
            pump_in      = 1'b0;
            indicator_in = IND_NORMAL;
         end
      end else if ((timer_in == '0) && pump_in) begin
         pump_in      = 1'b0;
         indicator_in = IND_NORMAL;
      end
   end

   // sample phase wraps at the read interval
   assign phase_inc = phase_ff + 16'd1;
   assign phase_in  = (phase_inc >= read_interval_ff) ? 16'd0 : phase_inc;

   // reported timer saturates at the field width
   assign timer_wide  = WIDE_BITS'(timer_in);
   assign manual_left = (timer_wide > WIDE_BITS'(16'hFFFF)) ? 16'hFFFF : timer_wide[15:0];

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_chan.item;
      end
   end

   // state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         auto_mode_ff <= 1'b1;
         pump_ff      <= 1'b0;
         indicator_ff <= IND_NORMAL;
         timer_ff     <= '0;
         phase_ff     <= '0;
         moisture_ff  <= '0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
         if (in_valid_ff) begin
            auto_mode_ff <= auto_mode_in;
            pump_ff      <= pump_in;
            indicator_ff <= indicator_in;
            timer_ff     <= timer_in;
            phase_ff     <= phase_in;
            moisture_ff  <= moisture_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid_ff) begin
         out_item_ff.pump_on     <= pump_in;
         out_item_ff.led_code    <= indicator_in;
         out_item_ff.auto_flag   <= auto_mode_in;
         out_item_ff.manual_left <= manual_left;
      end
   end

   // checks
   `ASSERT_ALWAYS(a_pump_shows_watering, clock, reset, !pump_ff || (indicator_ff == IND_WATERING))
   `ASSERT_ALWAYS(a_manual_idle_timer_stops_pump, clock, reset,
      auto_mode_ff || (timer_ff != '0) || !pump_ff)
   `ASSERT_ALWAYS(a_led_code_valid, clock, reset, indicator_ff != IND_UNUSED)
   `ASSERT_NEXT(a_tick_reaches_output, clock, reset, in_valid_ff && advance, out_valid_ff)

endmodule

`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// irrigation pump controller testbench
// drives one-second tick items into the controller and checks every status
// item against a cycle-free prediction of the pump, indicator, mode and
// manual timer; covers the corner cases, then random register settings and
// button sequences, with random idling and back-pressure on both channels
// ----------------------------------------------------------------------------
module testbench;
   import ipc_pkg::*;

   logic                   clock;
   logic                   reset;
   logic                   csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   ipc_stream_if #(.item_type(req_item_type)) req_if ();
   ipc_stream_if #(.item_type(rsp_item_type)) rsp_if ();

   irrigation_pump_controller #(
      .TIMER_BITS (TIMER_BITS_DEFAULT)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // shadow registers
   logic [9:0]  low_level      = LOW_THRESHOLD_RESET;
   logic [9:0]  high_level     = HIGH_THRESHOLD_RESET;
   logic [15:0] water_ticks    = MANUAL_DURATION_RESET;
   logic [15:0] sense_interval = READ_INTERVAL_RESET;

   // predicted controller state
   logic        in_auto       = 1'b1;
   logic        pump_running  = 1'b0;
   logic [1:0]  led_state     = IND_NORMAL;
   logic [15:0] timer_left    = '0;
   logic [15:0] sense_phase   = '0;
   logic [9:0]  held_moisture = '0;

   rsp_item_type expected_status_q[$];
   rsp_item_type want_status;

   int  mismatches      = 0;
   int  ticks_sent      = 0;
   int  statuses_seen   = 0;
   int  register_writes = 0;
   int  long_stalls     = 0;
   int  hold_off_cycles = 0;
   bit  idle_on         = 1'b0;

   // clock
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // one tick of the controller: returns the status item it produces
   function automatic rsp_item_type next_pump_status(input req_item_type tick);
      rsp_item_type status;
      // manual timer counts down first
      if (timer_left != '0)
         timer_left = timer_left - 1'b1;
      // mode toggle; dropping into manual stops a running pump
      if (tick.toggle_press) begin
         in_auto = ~in_auto;
         if (!in_auto && pump_running) begin
            pump_running = 1'b0;
            led_state    = IND_NORMAL;
         end
      end
      // manual press reloads the timer
      if (!in_auto && tick.water_press) begin
         timer_left = water_ticks;
         if (!pump_running) begin
            pump_running = 1'b1;
            led_state    = IND_WATERING;
         end
      end
      // latch the sample at the start of each read interval
      if (sense_phase == '0) begin
         held_moisture = tick.moisture_sample;
         if (!pump_running)
            led_state = (in_auto && held_moisture < low_level) ? IND_ALERT : IND_NORMAL;
      end
      // hysteresis in auto, timer expiry in manual
      if (in_auto) begin
         if (held_moisture < low_level && !pump_running) begin
            pump_running = 1'b1;
            led_state    = IND_WATERING;
         end
         if (pump_running && held_moisture > high_level) begin
            pump_running = 1'b0;
            led_state    = IND_NORMAL;
         end
      end else if (timer_left == '0 && pump_running) begin
         pump_running = 1'b0;
         led_state    = IND_NORMAL;
      end
      sense_phase = sense_phase + 1'b1;
      if (sense_phase >= sense_interval)
         sense_phase = '0;
      status.pump_on     = pump_running;
      status.led_code    = led_state;
      status.auto_flag   = in_auto;
      status.manual_left = timer_left;
      return status;
   endfunction

   // status check first, then prediction for the tick taken at this edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            statuses_seen++;
            if (expected_status_q.size() == 0) begin
               mismatches++;
               $display("%0t: status item with none expected, got %p", $time, rsp_if.item);
            end else begin
               want_status = expected_status_q.pop_front();
               if (rsp_if.item !== want_status) begin
                  mismatches++;
                  if (mismatches <= 40) begin
                     if (rsp_if.item.pump_on !== want_status.pump_on)
                        $display("%0t: pump_on expected %0d, actual %0d", $time,
                                 want_status.pump_on, rsp_if.item.pump_on);
                     if (rsp_if.item.led_code !== want_status.led_code)
                        $display("%0t: led_code expected %0d, actual %0d", $time,
                                 want_status.led_code, rsp_if.item.led_code);
                     if (rsp_if.item.auto_flag !== want_status.auto_flag)
                        $display("%0t: auto_flag expected %0d, actual %0d", $time,
                                 want_status.auto_flag, rsp_if.item.auto_flag);
                     if (rsp_if.item.manual_left !== want_status.manual_left)
                        $display("%0t: manual_left expected %0d, actual %0d", $time,
                                 want_status.manual_left, rsp_if.item.manual_left);
                  end
               end
            end
         end
         if (req_if.valid && req_if.ready) begin
            ticks_sent++;
            expected_status_q.push_back(next_pump_status(req_if.item));
         end
      end
   end

   // status receiver: random idling and the occasional long hold-off
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_cycles > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (hold_off_cycles - 1) @(posedge clock);
            hold_off_cycles = 0;
            long_stalls++;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(0, 6)) @(posedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // offer one tick item and hold it until taken
   task automatic send_tick(input logic toggle, input logic water, input logic [9:0] moisture);
      req_item_type tick;
      tick.toggle_press    = toggle;
      tick.water_press     = water;
      tick.moisture_sample = moisture;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.item  <= tick;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // stop offering and wait until every status item is back
   task automatic wait_for_results();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (expected_status_q.size() != 0);
   endtask

   // register write, mirrored into the shadow copy
   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      case (idx)
         CSR_LOW_THRESHOLD:   low_level      = value[9:0];
         CSR_HIGH_THRESHOLD:  high_level     = value[9:0];
         CSR_MANUAL_DURATION: water_ticks    = value;
         CSR_READ_INTERVAL:   sense_interval = value;
         default: ;
      endcase
      @(posedge clock);
      csr_write <= 1'b0;
      register_writes++;
   endtask

   // moisture mostly near the thresholds, sometimes anywhere or at the ends
   function automatic logic [9:0] pick_moisture();
      int centre;
      int level;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: centre = low_level;
         4, 5, 6:    centre = high_level;
         7, 8:       return 10'($urandom_range(0, 1023));
         default:    return $urandom_range(0, 1) ? 10'd1023 : 10'd0;
      endcase
      level = centre + $urandom_range(0, 40) - 20;
      if (level < 0)
         level = 0;
      if (level > 1023)
         level = 1023;
      return 10'(level);
   endfunction

   task automatic test_directed_cases();
      idle_on = 1'b0;
      // hysteresis at default settings
      send_tick(1'b0, 1'b0, 10'd0);
      send_tick(1'b0, 1'b1, 10'd500);   // water press in auto is ignored
      send_tick(1'b0, 1'b0, 10'd1023);
      send_tick(1'b0, 1'b0, 10'd300);   // exactly at low: no alert
      // manual mode, timer run and toggles with the pump on
      send_tick(1'b1, 1'b0, 10'd100);
      send_tick(1'b0, 1'b1, 10'd100);
      send_tick(1'b1, 1'b0, 10'd100);
      send_tick(1'b1, 1'b0, 10'd0);
      send_tick(1'b1, 1'b1, 10'd700);
      // zero duration and zero read interval
      wait_for_results();
      write_register(CSR_MANUAL_DURATION, 16'd0);
      write_register(CSR_READ_INTERVAL, 16'd0);
      send_tick(1'b1, 1'b1, 10'd50);
      send_tick(1'b0, 1'b1, 10'd1000);
      // crossed thresholds: start and stop in one tick
      wait_for_results();
      write_register(CSR_LOW_THRESHOLD, 16'd900);
      write_register(CSR_HIGH_THRESHOLD, 16'd100);
      send_tick(1'b1, 1'b0, 10'd500);
      send_tick(1'b0, 1'b0, 10'd950);
      // register extremes, upper data bits on the 10-bit registers
      wait_for_results();
      write_register(CSR_LOW_THRESHOLD, 16'd0);
      write_register(CSR_HIGH_THRESHOLD, 16'hFFFF);
      write_register(CSR_MANUAL_DURATION, 16'hFFFF);
      write_register(CSR_READ_INTERVAL, 16'hFFFF);
      send_tick(1'b0, 1'b0, 10'd0);
      send_tick(1'b1, 1'b1, 10'd512);
      send_tick(1'b0, 1'b0, 10'd1023);
      send_tick(1'b0, 1'b1, 10'd1);
      // short read interval
      wait_for_results();
      write_register(CSR_LOW_THRESHOLD, 16'd400);
      write_register(CSR_HIGH_THRESHOLD, 16'd600);
      write_register(CSR_MANUAL_DURATION, 16'd5);
      write_register(CSR_READ_INTERVAL, 16'd3);
      send_tick(1'b1, 1'b0, 10'd200);
      send_tick(1'b0, 1'b0, 10'd800);
      send_tick(1'b0, 1'b0, 10'd399);
      send_tick(1'b0, 1'b0, 10'd601);
   endtask

   task automatic test_random_phases(input int phases, input int per_phase);
      logic [15:0] low_pick;
      logic [15:0] high_pick;
      logic [15:0] ticks_pick;
      logic [15:0] interval_pick;
      for (int p = 0; p < phases; p++) begin
         wait_for_results();
         case ($urandom_range(0, 7))
            0:       low_pick = 16'd0;
            1:       low_pick = 16'd1023;
            default: low_pick = 16'($urandom_range(100, 600));
         endcase
         if ($urandom_range(0, 7) == 0)
            high_pick = 16'($urandom_range(0, 1023));
         else
            high_pick = (low_pick + 16'($urandom_range(0, 400)) > 16'd1023) ?
                        16'd1023 : low_pick + 16'($urandom_range(0, 400));
         case ($urandom_range(0, 9))
            0:       ticks_pick = 16'd0;
            1:       ticks_pick = 16'hFFFF;
            2:       ticks_pick = 16'($urandom_range(0, 65535));
            default: ticks_pick = 16'($urandom_range(1, 12));
         endcase
         case ($urandom_range(0, 11))
            0:       interval_pick = 16'd0;
            1:       interval_pick = 16'hFFFF;
            default: interval_pick = 16'($urandom_range(1, 4));
         endcase
         write_register(CSR_LOW_THRESHOLD, low_pick);
         write_register(CSR_HIGH_THRESHOLD, high_pick);
         write_register(CSR_MANUAL_DURATION, ticks_pick);
         write_register(CSR_READ_INTERVAL, interval_pick);
         // some phases run without idling
         idle_on = ($urandom_range(0, 3) != 0);
         for (int i = 0; i < per_phase; i++)
            send_tick($urandom_range(0, 9) == 0, $urandom_range(0, 3) == 0, pick_moisture());
      end
   endtask

   task automatic test_output_backpressure();
      idle_on         = 1'b1;
      hold_off_cycles = 80;
      // the sender keeps offering while the receiver holds off
      for (int i = 0; i < 30; i++)
         send_tick($urandom_range(0, 7) == 0, $urandom_range(0, 2) == 0, pick_moisture());
      wait_for_results();
   endtask

   task automatic test_unthrottled();
      idle_on = 1'b0;
      for (int i = 0; i < 60; i++)
         send_tick($urandom_range(0, 7) == 0, $urandom_range(0, 3) == 0, pick_moisture());
   endtask

   // reset, tests in turn, final verdict
   initial begin
      reset        <= 1'b1;
      csr_write    <= 1'b0;
      csr_index    <= '0;
      csr_data     <= '0;
      req_if.valid <= 1'b0;
      req_if.item  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_random_phases(7, 48);
      test_output_backpressure();
      test_unthrottled();

      wait_for_results();
      repeat (8) @(posedge clock);
      if (expected_status_q.size() != 0) begin
         mismatches++;
         $display("%0t: %0d status items never arrived", $time, expected_status_q.size());
      end
      $display("run covered %0d ticks, %0d status items, %0d register writes, %0d long stalls",
               ticks_sent, statuses_seen, register_writes, long_stalls);
      $display("%0d mismatches", mismatches);
      if (mismatches == 0)
         $display("** irrigation_pump_controller: PASSED **");
      else
         $display("** irrigation_pump_controller: FAILED **");
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("%0t: timeout with %0d status items outstanding", $time,
               expected_status_q.size());
      $display("** irrigation_pump_controller: FAILED **");
      $finish;
   end

endmodule
